// File: design/frc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Flood risk classifier package
// Shared types, register indexes and output codes.
// ----------------------------------------------------------------------------
package frc_pkg;

	localparam int unsigned CFG_IDX_W  = 3;
	localparam int unsigned CFG_DATA_W = 16;

	localparam logic [CFG_IDX_W-1:0] IDX_CAUTION_LEVEL = 3'd0;
	localparam logic [CFG_IDX_W-1:0] IDX_WARNING_LEVEL = 3'd1;
	localparam logic [CFG_IDX_W-1:0] IDX_DANGER_LEVEL  = 3'd2;
	localparam logic [CFG_IDX_W-1:0] IDX_WARNING_TIME  = 3'd3;
	localparam logic [CFG_IDX_W-1:0] IDX_DANGER_TIME   = 3'd4;

	localparam logic [2:0] CLS_NORMAL  = 3'd0;
	localparam logic [2:0] CLS_CAUTION = 3'd1;
	localparam logic [2:0] CLS_WARNING = 3'd2;
	localparam logic [2:0] CLS_DANGER  = 3'd3;
	localparam logic [2:0] CLS_FAULT   = 3'd4;

	localparam logic [1:0] STAGE_OFF  = 2'd0;
	localparam logic [1:0] STAGE_WARN = 2'd1;
	localparam logic [1:0] STAGE_FULL = 2'd3;

	localparam logic [6:0] DUTY_OFF  = 7'd0;
	localparam logic [6:0] DUTY_WARN = 7'd70;
	localparam logic [6:0] DUTY_FULL = 7'd100;

	// Load enables of the first three pipeline stages
	typedef struct packed {
		logic en_s1;
		logic en_s2;
		logic en_s3;
	} stage_en_t;

	// Per-sample flags carried alongside the arrival checks
	typedef struct packed {
		logic err;
		logic ir_danger;
		logic ir_warning;
		logic ir_caution;
		logic caution_ge;
	} sample_flags_t;

endpackage

// File: design/frc_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Flood risk classifier channels
// Sample channel and result channel, each a valid/ready beat.
// ----------------------------------------------------------------------------
interface frc_sample_if;
	logic               valid;
	logic               ready;
	logic        [15:0] level_mm;
	logic signed [15:0] rise_rate_mm_per_min;
	logic        [4:0]  ir_hits;
	logic               sensor_ok;
	logic               sensor_fault;

	modport source (
		output valid, level_mm, rise_rate_mm_per_min, ir_hits,
		       sensor_ok, sensor_fault,
		input  ready
	);
	modport sink (
		input  valid, level_mm, rise_rate_mm_per_min, ir_hits,
		       sensor_ok, sensor_fault,
		output ready
	);
endinterface

interface frc_result_if;
	logic       valid;
	logic       ready;
	logic [2:0] risk_level;
	logic [1:0] drive_stage;
	logic       pump_on;
	logic [6:0] pump_duty_pct;
	logic       emergency;

	modport source (
		output valid, risk_level, drive_stage, pump_on, pump_duty_pct, emergency,
		input  ready
	);
	modport sink (
		input  valid, risk_level, drive_stage, pump_on, pump_duty_pct, emergency,
		output ready
	);
endinterface

// File: design/flood_risk_classifier.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Flood risk classifier
// Classifies each water sensor sample as normal, caution, warning, danger or
// sensor error and drives the pump and emergency outputs from the class.
// ----------------------------------------------------------------------------
//  channel   direction  handshake         payload
//  sample    in         valid / ready     level, rise rate, IR hits, flags
//  result    out        valid / ready     risk, power stage, pump, duty, emergency
//  cfg       in         cfg_we            cfg_index, cfg_wdata (no read-back)
//
// One sample a cycle is taken while the result side is not stalled. Four
// register stages: capture and subtract, the two multiplications, the
// compares, then classify into the output register.
// Reset clears the stage valid bits and loads the register defaults.
// Each stage loads whenever it is empty or the next stage moves, so a stall
// on the result side holds every occupied stage and nothing is dropped.
// ----------------------------------------------------------------------------
module flood_risk_classifier #(
	parameter int unsigned NO_ARRIVAL_TIME = 65535
) (
	input  logic                                clk,
	input  logic                                arst_n,
	frc_sample_if.sink                          sample,
	frc_result_if.source                        result,
	input  logic                                cfg_we,
	input  logic [frc_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  logic [frc_pkg::CFG_DATA_W-1:0]      cfg_wdata
);

	// ------------------------------------------------------------------
	// Configuration registers
	// ------------------------------------------------------------------
	logic [15:0] caution_level_q;
	logic [15:0] warning_level_q;
	logic [15:0] danger_level_q;
	logic [15:0] warning_time_q;
	logic [15:0] danger_time_q;

	// Out-of-range indexes fall through and change nothing
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			caution_level_q <= 16'd300;
			warning_level_q <= 16'd500;
			danger_level_q  <= 16'd700;
			warning_time_q  <= 16'd600;
			danger_time_q   <= 16'd300;
		end else if (cfg_we) begin
			unique case (cfg_index)
				frc_pkg::IDX_CAUTION_LEVEL: caution_level_q <= cfg_wdata;
				frc_pkg::IDX_WARNING_LEVEL: warning_level_q <= cfg_wdata;
				frc_pkg::IDX_DANGER_LEVEL:  danger_level_q  <= cfg_wdata;
				frc_pkg::IDX_WARNING_TIME:  warning_time_q  <= cfg_wdata;
				frc_pkg::IDX_DANGER_TIME:   danger_time_q   <= cfg_wdata;
				default: ;
			endcase
		end
	end

	// ------------------------------------------------------------------
	// Stage control: valid bits and load enables
	// ------------------------------------------------------------------
	logic valid_s1;
	logic valid_s2;
	logic valid_s3;
	logic valid_s4;
	logic en_s4;
	frc_pkg::stage_en_t en;

	// Advance a stage when it is empty or its contents move on
	assign en_s4    = !valid_s4 || result.ready;
	assign en.en_s3 = !valid_s3 || en_s4;
	assign en.en_s2 = !valid_s2 || en.en_s3;
	assign en.en_s1 = !valid_s1 || en.en_s2;

	assign sample.ready = en.en_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
			valid_s4 <= 1'b0;
		end else begin
			if (en.en_s1) valid_s1 <= sample.valid;
			if (en.en_s2) valid_s2 <= valid_s1;
			if (en.en_s3) valid_s3 <= valid_s2;
			if (en_s4)    valid_s4 <= valid_s3;
		end
	end

	// ------------------------------------------------------------------
	// Sample flags: decode IR switches and sensor health on capture,
	// then carry them down the pipe
	// ------------------------------------------------------------------
	frc_pkg::sample_flags_t flags_s1;
	frc_pkg::sample_flags_t flags_s2;
	frc_pkg::sample_flags_t flags_s3;

	always_ff @(posedge clk) begin
		if (en.en_s1) begin
			flags_s1.err        <= !sample.sensor_ok || sample.sensor_fault;
			flags_s1.ir_danger  <= |sample.ir_hits[4:2];
			flags_s1.ir_warning <= sample.ir_hits[1];
			flags_s1.ir_caution <= sample.ir_hits[0];
			flags_s1.caution_ge <= sample.level_mm >= caution_level_q;
		end
		if (en.en_s2) flags_s2 <= flags_s1;
		if (en.en_s3) flags_s3 <= flags_s2;
	end

	// ------------------------------------------------------------------
	// Arrival checks against the warning and danger targets; each hit
	// already includes the level-at-or-above-target case
	// ------------------------------------------------------------------
	logic warn_hit;
	logic dang_hit;

	frc_arrival_chk #(
		.NO_ARRIVAL_TIME (16'(NO_ARRIVAL_TIME))
	) u_warn_chk (
		.clk    (clk),
		.en     (en),
		.level  (sample.level_mm),
		.rate   (sample.rise_rate_mm_per_min),
		.target (warning_level_q),
		.limit  (warning_time_q),
		.hit    (warn_hit)
	);

	frc_arrival_chk #(
		.NO_ARRIVAL_TIME (16'(NO_ARRIVAL_TIME))
	) u_dang_chk (
		.clk    (clk),
		.en     (en),
		.level  (sample.level_mm),
		.rate   (sample.rise_rate_mm_per_min),
		.target (danger_level_q),
		.limit  (danger_time_q),
		.hit    (dang_hit)
	);

	// ------------------------------------------------------------------
	// Classify: error first, then danger, warning, caution
	// ------------------------------------------------------------------
	logic [2:0] risk_d;

	always_comb begin
		priority if (flags_s3.err) begin
			risk_d = frc_pkg::CLS_FAULT;
		end else if (flags_s3.ir_danger || dang_hit) begin
			risk_d = frc_pkg::CLS_DANGER;
		end else if (flags_s3.ir_warning || warn_hit) begin
			risk_d = frc_pkg::CLS_WARNING;
		end else if (flags_s3.ir_caution || flags_s3.caution_ge) begin
			risk_d = frc_pkg::CLS_CAUTION;
		end else begin
			risk_d = frc_pkg::CLS_NORMAL;
		end
	end

	// ------------------------------------------------------------------
	// Output register: decode pump and emergency drive from the class
	// ------------------------------------------------------------------
	logic [2:0] risk_s4;
	logic [1:0] stage_s4;
	logic       pump_s4;
	logic [6:0] duty_s4;
	logic       emerg_s4;

	always_ff @(posedge clk) begin
		if (en_s4) begin
			risk_s4 <= risk_d;
			unique case (risk_d)
				frc_pkg::CLS_WARNING: begin
					stage_s4 <= frc_pkg::STAGE_WARN;
					pump_s4  <= 1'b1;
					duty_s4  <= frc_pkg::DUTY_WARN;
					emerg_s4 <= 1'b0;
				end
				frc_pkg::CLS_DANGER,
				frc_pkg::CLS_FAULT: begin
					stage_s4 <= frc_pkg::STAGE_FULL;
					pump_s4  <= 1'b1;
					duty_s4  <= frc_pkg::DUTY_FULL;
					emerg_s4 <= 1'b1;
				end
				default: begin
					stage_s4 <= frc_pkg::STAGE_OFF;
					pump_s4  <= 1'b0;
					duty_s4  <= frc_pkg::DUTY_OFF;
					emerg_s4 <= 1'b0;
				end
			endcase
		end
	end

	assign result.valid         = valid_s4;
	assign result.risk_level    = risk_s4;
	assign result.drive_stage   = stage_s4;
	assign result.pump_on       = pump_s4;
	assign result.pump_duty_pct = duty_s4;
	assign result.emergency     = emerg_s4;

	// ------------------------------------------------------------------
	// Assertions
	// ------------------------------------------------------------------
`ifndef ASSERT_OFF
	// A held result must also hold the beat waiting behind it
	a_hold_s3: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s3 && valid_s4 && !result.ready) |=> valid_s3)
		else $error("stage 3 beat dropped during stall");

	// An error beat drives full power and emergency
	a_error_drive: assert property (@(posedge clk) disable iff (!arst_n)
		(result.valid && result.risk_level == frc_pkg::CLS_FAULT) |->
		(result.emergency && result.drive_stage == frc_pkg::STAGE_FULL
		 && result.pump_duty_pct == frc_pkg::DUTY_FULL))
		else $error("error class without full drive");

	// A danger-time write lands in its register
	a_cfg_write: assert property (@(posedge clk) disable iff (!arst_n)
		(cfg_we && cfg_index == frc_pkg::IDX_DANGER_TIME) |=>
		(danger_time_q == $past(cfg_wdata)))
		else $error("danger time register not written");
`endif

endmodule

// File: design/frc_arrival_chk.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Flood risk arrival check
// Three-stage test of whether the water reaches a target level within a
// time limit, done by cross-multiplying instead of dividing.
// ----------------------------------------------------------------------------
module frc_arrival_chk #(
	parameter logic [15:0] NO_ARRIVAL_TIME = 16'd65535
) (
	input  logic                clk,
	input  frc_pkg::stage_en_t  en,
	input  logic [15:0]         level,
	input  logic signed [15:0]  rate,
	input  logic [15:0]         target,
	input  logic [15:0]         limit,
	output logic                hit
);

	// stage 1: differences and flags
	logic        ge_s1;
	logic        sat_s1;
	logic        rpos_s1;
	logic [15:0] diff_s1;
	logic [14:0] rmag_s1;
	logic [16:0] lim1_s1;

	// stage 2: both products
	logic        ge_s2;
	logic        sat_s2;
	logic        rpos_s2;
	logic [21:0] lhs_s2;
	logic [31:0] rhs_s2;

	// stage 3: verdict
	logic        hit_s3;

	always_ff @(posedge clk) begin
		if (en.en_s1) begin
			ge_s1   <= level >= target;
			sat_s1  <= limit >= NO_ARRIVAL_TIME;
			rpos_s1 <= !rate[15] && (rate != 16'sd0);
			diff_s1 <= target - level;
			rmag_s1 <= rate[14:0];
			lim1_s1 <= {1'b0, limit} + 17'd1;
		end
	end

	// diff * 60 as diff * 64 - diff * 4
	always_ff @(posedge clk) begin
		if (en.en_s2) begin
			ge_s2   <= ge_s1;
			sat_s2  <= sat_s1;
			rpos_s2 <= rpos_s1;
			lhs_s2  <= {diff_s1, 6'b0} - {4'b0, diff_s1, 2'b0};
			rhs_s2  <= 32'(lim1_s1) * 32'(rmag_s1);
		end
	end

	// floor(d*60/r) <= limit holds exactly when d*60 < (limit+1)*r
	always_ff @(posedge clk) begin
		if (en.en_s3) begin
			hit_s3 <= ge_s2 || sat_s2 || (rpos_s2 && ({10'b0, lhs_s2} < rhs_s2));
		end
	end

	assign hit = hit_s3;

endmodule

// File: verif/tb_flood_risk_classifier.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Flood risk classifier testbench
// Drives sensor samples and register writes into the classifier, predicts
// each class and its pump and emergency outputs from an independent model of
// the arrival-time rules, and checks every result beat in order under random
// idling on both channels.
// ----------------------------------------------------------------------------
module tb_flood_risk_classifier;

	typedef logic [frc_pkg::CFG_IDX_W-1:0] cfg_idx_t;

	localparam int unsigned NO_ARRIVAL_TIME = 65535;
	localparam time         RUN_LIMIT       = 2_000_000ns;
	localparam int          PHASES          = 7;
	localparam int          ITEMS_PER_PHASE = 62;
	localparam int          DRAIN_CYCLES    = 8;
	localparam cfg_idx_t    IDX_LAST        = '1;

	typedef struct packed {
		logic        [15:0] level;
		logic signed [15:0] rate;
		logic        [4:0]  ir;
		logic               valid;
		logic               fault;
	} sample_t;

	typedef struct packed {
		logic [2:0] risk;
		logic [1:0] stage;
		logic       pump;
		logic [6:0] duty;
		logic       emerg;
	} result_t;

	// Holds the register copy, works out the expected result of each accepted
	// sample and compares result beats against them in order.
	class risk_checker;
		bit [15:0] caution_mm = 16'd300;
		bit [15:0] warning_mm = 16'd500;
		bit [15:0] danger_mm  = 16'd700;
		bit [15:0] warning_s  = 16'd600;
		bit [15:0] danger_s   = 16'd300;
		result_t   expected_results[$];
		int        mismatches;

		function void set_register(cfg_idx_t idx, logic [15:0] val);
			case (idx)
				frc_pkg::IDX_CAUTION_LEVEL: caution_mm = val;
				frc_pkg::IDX_WARNING_LEVEL: warning_mm = val;
				frc_pkg::IDX_DANGER_LEVEL:  danger_mm  = val;
				frc_pkg::IDX_WARNING_TIME:  warning_s  = val;
				frc_pkg::IDX_DANGER_TIME:   danger_s   = val;
				default: ;
			endcase
		endfunction

		// Seconds until the level reaches the target at the given rate
		function bit [31:0] eta_s(bit [31:0] lvl, bit [31:0] target, int rate);
			bit [31:0] t;
			if (rate <= 0)
				return NO_ARRIVAL_TIME;
			if (lvl >= target)
				return 0;
			t = ((target - lvl) * 32'd60) / 32'(rate);
			if (t > NO_ARRIVAL_TIME)
				t = NO_ARRIVAL_TIME;
			return t;
		endfunction

		function result_t classify_sample(sample_t s);
			result_t   r;
			int        rate;
			bit [31:0] t_warn;
			bit [31:0] t_dang;
			rate   = s.rate;
			t_warn = eta_s(s.level, warning_mm, rate);
			t_dang = eta_s(s.level, danger_mm, rate);
			if (!s.valid || s.fault)
				r.risk = frc_pkg::CLS_FAULT;
			else if (s.ir[4:2] != 0 || s.level >= danger_mm || t_dang <= danger_s)
				r.risk = frc_pkg::CLS_DANGER;
			else if (s.ir[1] || s.level >= warning_mm || t_warn <= warning_s)
				r.risk = frc_pkg::CLS_WARNING;
			else if (s.ir[0] || s.level >= caution_mm)
				r.risk = frc_pkg::CLS_CAUTION;
			else
				r.risk = frc_pkg::CLS_NORMAL;
			r.stage = frc_pkg::STAGE_OFF;
			r.pump  = 1'b0;
			r.duty  = frc_pkg::DUTY_OFF;
			r.emerg = 1'b0;
			if (r.risk == frc_pkg::CLS_WARNING) begin
				r.stage = frc_pkg::STAGE_WARN;
				r.pump  = 1'b1;
				r.duty  = frc_pkg::DUTY_WARN;
			end else if (r.risk == frc_pkg::CLS_DANGER || r.risk == frc_pkg::CLS_FAULT) begin
				r.stage = frc_pkg::STAGE_FULL;
				r.pump  = 1'b1;
				r.duty  = frc_pkg::DUTY_FULL;
				r.emerg = 1'b1;
			end
			return r;
		endfunction

		function void note_sample(sample_t s);
			expected_results.push_back(classify_sample(s));
		endfunction

		task report(string msg);
			$display("%0t ns: mismatch: %s", $time, msg);
			mismatches++;
		endtask

		task check_result(result_t got);
			result_t want;
			if (expected_results.size() == 0) begin
				report($sformatf("result beat with no sample waiting (risk %0d)", got.risk));
				return;
			end
			want = expected_results.pop_front();
			if (got.risk !== want.risk)
				report($sformatf("risk_level got %0d want %0d", got.risk, want.risk));
			if (got.stage !== want.stage)
				report($sformatf("drive_stage got %0d want %0d", got.stage, want.stage));
			if (got.pump !== want.pump)
				report($sformatf("pump_on got %0d want %0d", got.pump, want.pump));
			if (got.duty !== want.duty)
				report($sformatf("pump_duty_pct got %0d want %0d", got.duty, want.duty));
			if (got.emerg !== want.emerg)
				report($sformatf("emergency got %0d want %0d", got.emerg, want.emerg));
		endtask
	endclass

	logic        clk;
	logic        arst_n;
	logic        cfg_we;
	cfg_idx_t    cfg_index;
	logic [15:0] cfg_wdata;
	bit          steady;   // set to hold both sides free of idling

	frc_sample_if smp ();
	frc_result_if res ();

	risk_checker sb = new;

	flood_risk_classifier #(
		.NO_ARRIVAL_TIME(NO_ARRIVAL_TIME)
	) u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.sample    (smp),
		.result    (res),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Hard stop: nothing correct takes anywhere near this long
	initial begin
		#RUN_LIMIT;
		$display("CHECK FAILED");
		$finish;
	end

	// Sample both channels at the rising edge; inputs only move at the falling
	// edge, so these are the values the block sees at the same edge.
	always @(posedge clk) begin
		if (smp.valid === 1'b1 && smp.ready === 1'b1)
			sb.note_sample('{smp.level_mm, smp.rise_rate_mm_per_min, smp.ir_hits,
				smp.sensor_ok, smp.sensor_fault});
		if (res.valid === 1'b1 && res.ready === 1'b1)
			sb.check_result('{res.risk_level, res.drive_stage, res.pump_on,
				res.pump_duty_pct, res.emergency});
	end

	// Result side: stall about one cycle in five unless a steady stretch is on
	initial begin
		res.ready = 1'b0;
		forever @(negedge clk)
			res.ready <= steady || ($urandom_range(99) >= 20);
	end

	function automatic sample_t make_sample(int lvl, int rate, int ir, bit ok, bit bad);
		sample_t s;
		s.level = 16'(lvl);
		s.rate  = 16'(rate);
		s.ir    = 5'(ir);
		s.valid = ok;
		s.fault = bad;
		return s;
	endfunction

	// Mostly levels close below a threshold with modest positive rates, so the
	// arrival times land on either side of the time registers; the rest is
	// anything the fields allow.
	function automatic sample_t random_sample();
		sample_t s;
		int      base;
		int      lvl;
		int      rate;
		int      pick;
		case ($urandom_range(2))
			0:       base = sb.caution_mm;
			1:       base = sb.warning_mm;
			default: base = sb.danger_mm;
		endcase
		if ($urandom_range(99) < 30)
			lvl = $urandom_range(65535);
		else begin
			lvl = base - int'($urandom_range(2000)) + int'($urandom_range(40));
			if (lvl < 0)
				lvl = 0;
			if (lvl > 65535)
				lvl = 65535;
		end
		pick = $urandom_range(99);
		if (pick < 15)
			rate = int'($urandom_range(65535));
		else if (pick < 30)
			rate = 0 - int'($urandom_range(200));
		else
			rate = $urandom_range(400, 1);
		s = make_sample(lvl, rate, ($urandom_range(99) < 25) ? $urandom_range(31) : 0,
			$urandom_range(99) >= 8, $urandom_range(99) < 8);
		return s;
	endfunction

	// Offer one beat, idling first at random, and return on the falling edge
	// after it is taken. Valid is left high for the next call to reuse.
	task automatic push_sample(input sample_t s);
		while (!steady && $urandom_range(99) < 20) begin
			smp.valid <= 1'b0;
			@(negedge clk);
		end
		smp.valid                <= 1'b1;
		smp.level_mm             <= s.level;
		smp.rise_rate_mm_per_min <= s.rate;
		smp.ir_hits              <= s.ir;
		smp.sensor_ok            <= s.valid;
		smp.sensor_fault         <= s.fault;
		@(posedge clk);
		while (smp.ready !== 1'b1)
			@(posedge clk);
		@(negedge clk);
	endtask

	// Drop valid and wait until every expected beat is back, then let the
	// pipeline settle before anything else changes.
	task automatic wait_until_drained();
		smp.valid <= 1'b0;
		while (sb.expected_results.size() != 0)
			@(negedge clk);
		repeat (DRAIN_CYCLES) @(negedge clk);
	endtask

	task automatic write_register(input cfg_idx_t idx, input logic [15:0] val);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= val;
		@(negedge clk);
		cfg_we <= 1'b0;
		@(negedge clk);
		sb.set_register(idx, val);
	endtask

	initial begin : stimulus
		sample_t     directed[$];
		logic [15:0] regs[5];
		int          base;

		// Every input known from time zero while reset is held low
		arst_n                   = 1'b0;
		steady                   = 1'b0;
		cfg_we                   = 1'b0;
		cfg_index                = '0;
		cfg_wdata                = '0;
		smp.valid                = 1'b0;
		smp.level_mm             = '0;
		smp.rise_rate_mm_per_min = '0;
		smp.ir_hits              = '0;
		smp.sensor_ok            = 1'b0;
		smp.sensor_fault         = 1'b0;
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Directed part against the reset thresholds: field extremes, the
		// untrusted-sensor cases, each IR switch alone, the level boundaries
		// and arrival times just inside and outside their limits.
		directed.push_back(make_sample(0, 0, 0, 1, 0));
		directed.push_back(make_sample(65535, 32767, 31, 1, 0));
		directed.push_back(make_sample(0, -32768, 0, 1, 0));
		directed.push_back(make_sample(65535, -1, 0, 1, 0));
		directed.push_back(make_sample(0, 0, 0, 0, 0));
		directed.push_back(make_sample(0, 0, 0, 1, 1));
		directed.push_back(make_sample(65535, 32767, 31, 0, 1));
		directed.push_back(make_sample(0, 0, 1, 1, 0));
		directed.push_back(make_sample(0, 0, 2, 1, 0));
		directed.push_back(make_sample(0, 0, 4, 1, 0));
		directed.push_back(make_sample(0, 0, 8, 1, 0));
		directed.push_back(make_sample(0, 0, 16, 1, 0));
		directed.push_back(make_sample(299, 0, 0, 1, 0));
		directed.push_back(make_sample(300, 0, 0, 1, 0));
		directed.push_back(make_sample(499, -5, 0, 1, 0));
		directed.push_back(make_sample(500, -5, 0, 1, 0));
		directed.push_back(make_sample(699, 0, 0, 1, 0));
		directed.push_back(make_sample(700, 0, 0, 1, 0));
		directed.push_back(make_sample(0, 1, 0, 1, 0));       // far off: normal
		directed.push_back(make_sample(690, 2, 0, 1, 0));     // danger exactly on time
		directed.push_back(make_sample(689, 2, 0, 1, 0));     // one mm short of it
		directed.push_back(make_sample(400, 10, 0, 1, 0));    // warning exactly on time
		directed.push_back(make_sample(400, 9, 0, 1, 0));     // just too slow
		directed.push_back(make_sample(400, 3, 0, 1, 0));     // rising but caution only
		foreach (directed[i])
			push_sample(directed[i]);
		wait_until_drained();

		// Random phases, each under its own register setting: all zero, all
		// ones, high levels with zero times, anything at all (thresholds out
		// of order), two ordered settings and finally the reset values again.
		for (int phase = 0; phase < PHASES; phase++) begin
			case (phase)
				0: regs = '{16'd0, 16'd0, 16'd0, 16'd0, 16'd0};
				1: regs = '{16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF};
				2: regs = '{16'hFFFF, 16'hFFFF, 16'hFFFF, 16'd0, 16'd0};
				3: begin
					foreach (regs[i])
						regs[i] = 16'($urandom);
				end
				4, 5: begin
					base    = $urandom_range(20000);
					regs[0] = 16'(base);
					base    = base + $urandom_range(20000);
					regs[1] = 16'(base);
					regs[2] = 16'(base + $urandom_range(20000));
					regs[3] = 16'($urandom_range(3000));
					regs[4] = 16'($urandom_range(3000));
				end
				default: regs = '{16'd300, 16'd500, 16'd700, 16'd600, 16'd300};
			endcase
			write_register(frc_pkg::IDX_CAUTION_LEVEL, regs[0]);
			write_register(frc_pkg::IDX_WARNING_LEVEL, regs[1]);
			write_register(frc_pkg::IDX_DANGER_LEVEL,  regs[2]);
			write_register(frc_pkg::IDX_WARNING_TIME,  regs[3]);
			write_register(frc_pkg::IDX_DANGER_TIME,   regs[4]);
			// Unused indexes must leave every register alone
			write_register(cfg_idx_t'($urandom_range(IDX_LAST, frc_pkg::IDX_DANGER_TIME + 1)),
				16'($urandom));

			// No idling on either side through one whole phase
			steady = (phase == 4);
			repeat (ITEMS_PER_PHASE)
				push_sample(random_sample());
			wait_until_drained();
			steady = 1'b0;
		end

		if (sb.mismatches == 0 && sb.expected_results.size() == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

endmodule

// File: filelist.f
design/frc_pkg.sv
design/frc_if.sv
design/frc_arrival_chk.sv
design/flood_risk_classifier.sv
verif/tb_flood_risk_classifier.sv
